FILE: rtl/core/dtfa_pkg.sv
// Shared types, codes and constant tables for the decimal text to fixed point adder.
// No dependencies; imported by dtfa_char_parser and decimal_text_to_fixed_adder.
`default_nettype none

package dtfa_pkg;

  // Fixed point scale: values are in units of 10^-FRAC_DIGITS (range 0..9)
  localparam int unsigned FRAC_DIGITS = 6;
  localparam logic [5:0] FRAC_LIM = 6'(FRAC_DIGITS);
  localparam logic [5:0] FRAC_COUNT_MAX = 6'd63;

  localparam logic signed [63:0] ADDEND_RESET = -64'sd123456000;

  // Error codes
  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_CHAR    = 3'd1;
  localparam logic [2:0] ERR_POINT2  = 3'd2;
  localparam logic [2:0] ERR_NODIGIT = 3'd3;
  localparam logic [2:0] ERR_OVF     = 3'd4;

  // Magnitude limits
  localparam logic [63:0] MAG_LIMIT   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  // Largest magnitude that still takes one more digit: (2^63 - d) / 10
  localparam logic [63:0] DIGIT_THRESH      = 64'd922337203685477580;
  localparam logic [63:0] DIGIT_THRESH_NINE = 64'd922337203685477579;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Parser state after the final character, handed to the finish pipeline
  typedef struct packed {
    logic        negative;
    logic        point_pending;
    logic [5:0]  frac_count;
    logic [63:0] magnitude;
    logic [2:0]  err_code;
  } parse_snap_t;

  // 10^k for k = 0..9
  function automatic logic [29:0] pow10(input logic [3:0] k);
    logic [29:0] r;
    case (k)
      4'd0: r = 30'd1;
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      4'd9: r = 30'd1000000000;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

  // Signed limit (2^63 if negative, else 2^63-1) divided by 10^k
  function automatic logic [63:0] limit_div(input logic neg, input logic [3:0] k);
    logic [63:0] r;
    case (k)
      4'd0: r = neg ? MAG_LIMIT : MAG_MAX_POS;
      4'd1: r = 64'd922337203685477580;
      4'd2: r = 64'd92233720368547758;
      4'd3: r = 64'd9223372036854775;
      4'd4: r = 64'd922337203685477;
      4'd5: r = 64'd92233720368547;
      4'd6: r = 64'd9223372036854;
      4'd7: r = 64'd922337203685;
      4'd8: r = 64'd92233720368;
      4'd9: r = 64'd9223372036;
      default: r = neg ? MAG_LIMIT : MAG_MAX_POS;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dtfa_char_parser.sv
// Per-character syntax check and magnitude build-up for one decimal number.
// Depends on dtfa_pkg; instantiated by decimal_text_to_fixed_adder.
`default_nettype none

module dtfa_char_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [7:0]         char_code,
  input  wire logic               last_char,
  output dtfa_pkg::parse_snap_t   snap
);
  import dtfa_pkg::*;

  logic        at_first_char, at_first_char_next;
  logic        is_negative, is_negative_next;
  logic        seen_point, seen_point_next;
  logic        point_pending, point_pending_next;
  logic [5:0]  frac_count, frac_count_next;
  logic [63:0] magnitude, magnitude_next;
  logic [2:0]  error_seen, error_seen_next;

  logic        is_digit;
  logic [3:0]  digit;
  logic [63:0] times_ten;
  logic        digit_ovf;
  logic        syntax_hold;
  logic        keep;

  assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit     = char_code[3:0];
  assign times_ten = {magnitude[60:0], 3'b000} + {magnitude[62:0], 1'b0} + 64'(digit);
  assign digit_ovf = magnitude > ((digit == 4'd9) ? DIGIT_THRESH_NINE : DIGIT_THRESH);
  // a syntax error freezes everything until the last character
  assign syntax_hold = (error_seen == ERR_CHAR) || (error_seen == ERR_POINT2) ||
                       (error_seen == ERR_NODIGIT);

  always_comb begin
    at_first_char_next = at_first_char;
    is_negative_next   = is_negative;
    seen_point_next    = seen_point;
    point_pending_next = point_pending;
    frac_count_next    = frac_count;
    magnitude_next     = magnitude;
    error_seen_next    = error_seen;
    keep               = 1'b1;
    if (take) begin
      at_first_char_next = 1'b0;
      if (!syntax_hold) begin
        point_pending_next = 1'b0;
        if (point_pending && !is_digit) begin
          error_seen_next = ERR_NODIGIT;
        end else if (is_digit) begin
          if (seen_point) begin
            keep = frac_count < FRAC_LIM;
            if (frac_count != FRAC_COUNT_MAX) begin
              frac_count_next = frac_count + 6'd1;
            end
          end
          if (keep && (error_seen != ERR_OVF)) begin
            if (digit_ovf) begin
              error_seen_next = ERR_OVF;
            end else begin
              magnitude_next = times_ten;
            end
          end
        end else if (char_code == CHAR_POINT) begin
          if (seen_point) begin
            error_seen_next = ERR_POINT2;
          end else begin
            seen_point_next    = 1'b1;
            point_pending_next = 1'b1;
          end
        end else if (((char_code == CHAR_PLUS) || (char_code == CHAR_MINUS)) && at_first_char) begin
          is_negative_next = (char_code == CHAR_MINUS);
        end else begin
          error_seen_next = ERR_CHAR;
        end
      end
    end
  end

  assign snap.negative      = is_negative_next;
  assign snap.point_pending = point_pending_next;
  assign snap.frac_count    = frac_count_next;
  assign snap.magnitude     = magnitude_next;
  assign snap.err_code      = error_seen_next;

  always_ff @(posedge clk) begin
    if (rst || (take && last_char)) begin
      at_first_char <= 1'b1;
      is_negative   <= 1'b0;
      seen_point    <= 1'b0;
      point_pending <= 1'b0;
      frac_count    <= 6'd0;
      magnitude     <= 64'd0;
      error_seen    <= ERR_OK;
    end else begin
      at_first_char <= at_first_char_next;
      is_negative   <= is_negative_next;
      seen_point    <= seen_point_next;
      point_pending <= point_pending_next;
      frac_count    <= frac_count_next;
      magnitude     <= magnitude_next;
      error_seen    <= error_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && last_char |=> at_first_char && (error_seen == ERR_OK) && (magnitude == 64'd0))
    else $error("parser state not cleared after last character");

  a_no_point_no_frac: assert property (@(posedge clk) disable iff (rst)
    !seen_point |-> (frac_count == 6'd0) && !point_pending)
    else $error("fraction state without a point");

  a_syntax_sticky: assert property (@(posedge clk) disable iff (rst)
    take && !last_char && syntax_hold |=> error_seen == $past(error_seen))
    else $error("syntax error code changed before last character");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/decimal_text_to_fixed_adder.sv
// Throughput: one character per cycle while back-pressure leaves s_tready high; a new number
// may start right after a last character. Rate set by the per-character parser (multiply by ten
// and add) plus a 4-register finish pipeline: parser snapshot, scale-multiply partials,
// product merge, addend add/saturate.
// Reset: parser back to the start of a number, finish pipeline emptied, addend = -123.456.
// Depends on dtfa_pkg and dtfa_char_parser.
`default_nettype none

module decimal_text_to_fixed_adder (
  input  wire logic        clk,
  input  wire logic        rst,
  // character stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // last_char
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [63:0] sum_value, [69:64] fraction_digits, rest zero
  output logic [3:0]       m_tuser,   // [0] well_formed, [3:1] error_code
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import dtfa_pkg::*;

  localparam logic REG_ADDEND = 1'b0;   // register index, paddr[3]

  // ---------------- register port ----------------
  logic        cfg_write;
  logic [63:0] addend;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3] == REG_ADDEND) ? addend : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      addend <= ADDEND_RESET;
    end else if (cfg_write && (paddr[3] == REG_ADDEND)) begin
      addend <= pwdata;
    end
  end

  // ---------------- pipeline flow control ----------------
  // Each stage loads when empty or when the next one moves, so bubbles collapse behind a
  // waiting result, which stalls a stage only when every stage between them is full.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic take;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= take && s_tlast;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // ---------------- character parser ----------------
  parse_snap_t snap;

  dtfa_char_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (s_tdata),
    .last_char (s_tlast),
    .snap      (snap)
  );

  // ---------------- stage 1: final checks, scale partial products ----------------
  parse_snap_t s1;
  logic [2:0]  err1_syn;
  logic [5:0]  fc_min1;
  logic [3:0]  shift1;
  logic [29:0] scale1;
  logic        scale_ovf1;
  logic [2:0]  err1;
  logic [61:0] lo1;
  logic [61:0] hi1;

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= snap;
  end

  // point as the last character: flagged unless a syntax error already stands
  assign err1_syn = (s1.point_pending &&
                     ((s1.err_code == ERR_OK) || (s1.err_code == ERR_OVF))) ?
                    ERR_NODIGIT : s1.err_code;
  assign fc_min1    = (s1.frac_count < FRAC_LIM) ? s1.frac_count : FRAC_LIM;
  assign shift1     = 4'(FRAC_LIM - fc_min1);
  assign scale1     = pow10(shift1);
  assign scale_ovf1 = s1.magnitude > limit_div(s1.negative, shift1);
  assign err1       = ((err1_syn == ERR_OK) && scale_ovf1) ? ERR_OVF : err1_syn;
  // 64x30 product split in two 32x30 halves; only the low 32 bits of the
  // upper half matter once the range check has passed
  assign lo1 = s1.magnitude[31:0] * scale1;
  assign hi1 = s1.magnitude[63:32] * scale1;

  // ---------------- stage 2: merge product, select magnitude ----------------
  logic [2:0]  err2;
  logic        neg2;
  logic [5:0]  fc2;
  logic [61:0] lo2;
  logic [31:0] hi2;
  logic [63:0] prod2;
  logic [63:0] mag_sel2;
  logic [5:0]  fd_sel2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      err2 <= err1;
      neg2 <= s1.negative;
      fc2  <= s1.frac_count;
      lo2  <= lo1;
      hi2  <= hi1[31:0];
    end
  end

  assign prod2 = {hi2, 32'd0} + {2'b00, lo2};

  always_comb begin
    case (err2)
      ERR_OK: begin
        mag_sel2 = prod2;
        fd_sel2  = fc2;
      end
      ERR_OVF: begin
        mag_sel2 = neg2 ? MAG_LIMIT : MAG_MAX_POS;
        fd_sel2  = fc2;
      end
      default: begin
        mag_sel2 = 64'd0;
        fd_sel2  = 6'd0;
      end
    endcase
  end

  // ---------------- stage 3: add addend with saturation ----------------
  logic [2:0]  err3;
  logic        neg3;
  logic [5:0]  fd3;
  logic [63:0] mag3;
  logic [64:0] sum65;
  logic [63:0] sum3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      err3 <= err2;
      neg3 <= neg2;
      fd3  <= fd_sel2;
      mag3 <= mag_sel2;
    end
  end

  // 65-bit exact sum: addend in [-2^63, 2^63), magnitude at most 2^63
  assign sum65 = neg3 ? ({addend[63], addend} - {1'b0, mag3})
                      : ({addend[63], addend} + {1'b0, mag3});

  always_comb begin
    if ((err3 != ERR_OK) && (err3 != ERR_OVF)) begin
      sum3 = 64'd0;
    end else if (sum65[64] != sum65[63]) begin
      sum3 = sum65[64] ? MAG_LIMIT : MAG_MAX_POS;
    end else begin
      sum3 = sum65[63:0];
    end
  end

  // ---------------- stage 4: result register ----------------
  logic        valid_o;
  logic [2:0]  err_o;
  logic [63:0] sum_o;
  logic [5:0]  fd_o;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      valid_o <= (err3 == ERR_OK);
      err_o   <= err3;
      sum_o   <= sum3;
      fd_o    <= fd3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {2'b00, fd_o, sum_o};
  assign m_tuser  = {err_o, valid_o};

`ifndef SYNTHESIS
  a_pos_mag_range: assert property (@(posedge clk) disable iff (rst)
    v3 && (err3 == ERR_OK) && !neg3 |-> !mag3[63])
    else $error("positive magnitude beyond signed range");

  a_syntax_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser[3:1] == ERR_CHAR) || (m_tuser[3:1] == ERR_POINT2) ||
                 (m_tuser[3:1] == ERR_NODIGIT)) |-> (m_tdata == 72'd0))
    else $error("syntax error result carries a value");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy1 |=> v1 && $stable(s1))
    else $error("stalled stage 1 lost its request");
`endif

endmodule

`default_nettype wire

FILE: bench/decimal_text_to_fixed_adder_test.sv
// Self-checking bench for decimal_text_to_fixed_adder: streams number text one character
// per request and checks every result against an in-bench parser. Needs dtfa_pkg and the RTL.
`timescale 1ns / 1ps

module decimal_text_to_fixed_adder_test;
  import dtfa_pkg::*;

  localparam int STALL_LIMIT = 1000;     // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 8;       // extra settling once all results are back
  localparam logic [3:0] ADDR_ADDEND = 4'd0;
  localparam logic [63:0] ADDEND_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ADDEND_MIN = 64'h8000_0000_0000_0000;

  // One expected result: the fields checked on m_tuser and m_tdata
  typedef struct packed {
    logic        ok;
    logic [2:0]  code;
    logic [63:0] sum;
    logic [5:0]  digits;
  } number_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] char_code
  logic        s_tlast;    // last_char
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;    // [63:0] sum_value, [69:64] fraction_digits
  logic [3:0]  m_tuser;    // [0] well_formed, [3:1] error_code
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  decimal_text_to_fixed_adder u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Parser mirror: state of the number in flight plus the addend register
  logic        num_first;
  logic        num_negative;
  logic        num_point;
  logic        num_point_open;   // point seen, digit still owed
  logic [5:0]  num_frac;
  logic [63:0] num_mag;
  logic [2:0]  num_err;
  logic [63:0] addend_cfg;

  number_result_t pending_sums[$];
  logic [7:0]     text_buf[$];     // characters of the next number to send
  int             failures = 0;
  int             chars_sent = 0;
  int             stall_cycles = 0;
  int             src_idle_pct = 0;
  int             sink_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------------
  function automatic void clear_number();
    num_first = 1'b1;
    num_negative = 1'b0;
    num_point = 1'b0;
    num_point_open = 1'b0;
    num_frac = '0;
    num_mag = '0;
    num_err = ERR_OK;
  endfunction

  // First syntax error wins; a syntax error overrides an earlier overflow
  function automatic void flag_syntax(input logic [2:0] code);
    if (num_err == ERR_OK || num_err == ERR_OVF) num_err = code;
  endfunction

  function automatic logic [63:0] add_saturated(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? MAG_LIMIT : MAG_MAX_POS;
    return s;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic        was_first;
    logic        keep;
    logic [63:0] d;
    was_first = num_first;
    num_first = 1'b0;
    // after a syntax error the rest of the number is swallowed
    if (num_err != ERR_OK && num_err != ERR_OVF) return;
    if (num_point_open) begin
      num_point_open = 1'b0;
      if (c < CHAR_ZERO || c > CHAR_NINE) begin
        flag_syntax(ERR_NODIGIT);
        return;
      end
    end
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = 64'(c - CHAR_ZERO);
      keep = 1'b1;
      if (num_point) begin
        keep = (num_frac < FRAC_LIM);      // extra fraction digits are dropped
        if (num_frac < FRAC_COUNT_MAX) num_frac = num_frac + 6'd1;
      end
      if (keep && num_err != ERR_OVF) begin
        if (num_mag > (MAG_LIMIT - d) / 64'd10) num_err = ERR_OVF;
        else num_mag = num_mag * 64'd10 + d;
      end
    end else if (c == CHAR_POINT) begin
      if (num_point) begin
        flag_syntax(ERR_POINT2);
      end else begin
        num_point = 1'b1;
        num_point_open = 1'b1;
      end
    end else if ((c == CHAR_PLUS || c == CHAR_MINUS) && was_first) begin
      num_negative = (c == CHAR_MINUS);
    end else begin
      flag_syntax(ERR_CHAR);
    end
  endfunction

  // Scale to FRAC_DIGITS, apply sign and addend, then start a fresh number
  function automatic number_result_t close_number();
    number_result_t r;
    logic [63:0]    limit;
    logic [63:0]    scale;
    logic [63:0]    parsed;
    int             shift;
    if (num_point_open && num_err != ERR_CHAR && num_err != ERR_POINT2)
      flag_syntax(ERR_NODIGIT);
    limit = num_negative ? MAG_LIMIT : MAG_MAX_POS;
    if (num_err == ERR_OK) begin
      shift = (num_frac < FRAC_LIM) ? int'(FRAC_DIGITS) - int'(num_frac) : 0;
      scale = 64'd1;
      for (int i = 0; i < shift; i++) scale = scale * 64'd10;
      if (num_mag > limit / scale) num_err = ERR_OVF;
      else num_mag = num_mag * scale;
    end
    r.ok = (num_err == ERR_OK);
    r.code = num_err;
    r.sum = '0;
    r.digits = '0;
    if (num_err == ERR_OK || num_err == ERR_OVF) begin
      parsed = (num_err == ERR_OVF) ? limit : num_mag;
      if (num_negative) parsed = 64'd0 - parsed;
      r.sum = add_saturated(parsed, addend_cfg);
      r.digits = num_frac;
    end
    clear_number();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h got %h", $time, what, want_v, got_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    number_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result, expected none got tuser %h tdata %h",
                 $time, m_tuser, m_tdata);
        failures++;
      end else begin
        want = pending_sums.pop_front();
        check_field("well_formed", 64'(want.ok), 64'(m_tuser[0]));
        check_field("error_code", 64'(want.code), 64'(m_tuser[3:1]));
        check_field("sum_value", want.sum, m_tdata[63:0]);
        check_field("fraction_digits", 64'(want.digits), 64'(m_tdata[69:64]));
      end
    end
  end

  // Any handshake on any port counts as progress
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Receiver backpressure, redrawn every cycle
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One character request; random gaps before it at the current sender idle rate
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = c;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    parse_char(c);
    if (last) pending_sums.insert(pending_sums.size(), close_number());
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
    send_text();
  endtask

  // Sender goes quiet until every result is back, then lets the pipeline settle
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of the addend, then a read back of the same register
  task automatic write_addend(input logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_ADDEND;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    addend_cfg = value;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: addend read back expected %h got %h", $time, value, prdata);
      failures++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Number text generation
  // ---------------------------------------------------------------------------
  task automatic add_digits(input int n);
    repeat (n) text_buf.insert(text_buf.size(), CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_prefix(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
  endtask

  // Well-formed number: optional sign, integer digits, optional point and fraction.
  // Lengths are biased toward the digit overflow and scaling overflow boundaries.
  task automatic build_number();
    int pick;
    text_buf.delete();
    pick = $urandom_range(9);
    if (pick < 3) text_buf.insert(text_buf.size(), CHAR_MINUS);
    else if (pick < 5) text_buf.insert(text_buf.size(), CHAR_PLUS);
    pick = $urandom_range(99);
    if (pick < 8) begin
      // no integer part
    end else if (pick < 70) begin
      add_digits($urandom_range(1, 6));
    end else if (pick < 84) begin
      add_digits($urandom_range(7, 12));
    end else if (pick < 92) begin
      // right at 2^63 / 10^6: overflow only shows when the fraction is scaled in
      add_prefix("922337203685");
      add_digits($urandom_range(0, 2));
    end else if (pick < 97) begin
      // right at 2^63 / 10: overflow on the last digit or two
      add_prefix("92233720368547758");
      add_digits($urandom_range(0, 4));
    end else begin
      add_digits($urandom_range(18, 22));
    end
    if ($urandom_range(99) < 55) begin
      text_buf.insert(text_buf.size(), CHAR_POINT);
      pick = $urandom_range(99);
      if (pick < 78) add_digits($urandom_range(1, 6));
      else if (pick < 98) add_digits($urandom_range(7, 9));
      else add_digits($urandom_range(60, 66));    // count saturates at 63
    end
    if (text_buf.size() == 0) add_digits(1);
  endtask

  // Break a well-formed number in one place
  task automatic corrupt_number();
    int at;
    at = $urandom_range(text_buf.size() - 1);
    case ($urandom_range(4))
      0: text_buf[at] = 8'($urandom_range(255));
      1: text_buf.insert(at, CHAR_POINT);
      2: text_buf.insert(text_buf.size(), CHAR_POINT);
      3: text_buf.insert(at + 1, $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
      default: text_buf.insert(at, 8'h61 + 8'($urandom_range(25)));
    endcase
  endtask

  // Short runs of arbitrary bytes mixed with number characters
  task automatic build_noise();
    string pool;
    pool = "0123456789.+-";
    text_buf.delete();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(1)) text_buf.insert(text_buf.size(), 8'($urandom_range(255)));
      else text_buf.insert(text_buf.size(), pool[$urandom_range(pool.len() - 1)]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Valid forms with the reset addend: sign alone, leading point, truncation
  task automatic test_number_forms();
    send_string("-");
    send_string("+");
    send_string(".5");
    send_string(".1234567");
    wait_for_results();
  endtask

  // Bad characters (all-zero and all-one codes), misplaced sign, second point,
  // point as the final character
  task automatic test_syntax_errors();
    text_buf.delete();
    text_buf.insert(text_buf.size(), 8'h00);
    send_text();
    text_buf.delete();
    text_buf.insert(text_buf.size(), 8'hFF);
    send_text();
    send_string("+-");
    send_string(".1.");
    send_string("1.");
    wait_for_results();
  endtask

  // Integer part too large once scaled to the fixed-point unit
  task automatic test_overflow();
    send_string("9999999999999");
    wait_for_results();
  endtask

  // Mostly well-formed numbers, some broken ones, a little noise
  task automatic test_mixed_traffic(input int char_quota);
    int start;
    int pick;
    start = chars_sent;
    while (chars_sent - start < char_quota) begin
      pick = $urandom_range(99);
      build_number();
      if (pick >= 95) build_noise();
      else if (pick >= 80) corrupt_number();
      send_text();
      // now and then hold the sender until the pipeline is empty
      if ($urandom_range(49) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Addend at both ends of the range so sums saturate in each direction
  task automatic test_addend_saturation(input int char_quota);
    write_addend(ADDEND_MAX);
    test_mixed_traffic(char_quota);
    write_addend(ADDEND_MIN);
    test_mixed_traffic(char_quota);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    addend_cfg = 64'(ADDEND_RESET);
    clear_number();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender idles often, receiver stalls most cycles
    src_idle_pct = 38;
    sink_idle_pct = 75;
    test_number_forms();
    test_syntax_errors();
    test_overflow();
    test_mixed_traffic(350);
    write_addend(64'd0);
    test_mixed_traffic(300);

    // roles swapped
    src_idle_pct = 75;
    sink_idle_pct = 38;
    test_addend_saturation(300);

    // full rate both ways
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_addend({$urandom, $urandom});
    test_mixed_traffic(250);
    write_addend(64'($signed($urandom_range(2000000000)) - 64'sd1000000000));
    test_mixed_traffic(250);

    wait_for_results();
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
